[hw/rtl/rti_pkg.sv]
// Shared types and constants of the ray/triangle intersection pipeline.
`default_nettype none
package rti_pkg;

  localparam int FIELD_W   = 48;
  localparam int DIST_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DET_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 1'b1;

  localparam logic [CFG_W-1:0] DET_THRESHOLD_RST = 32'd1;
  localparam logic [CFG_W-1:0] MIN_DISTANCE_RST  = 32'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] ray_origin;
    logic [FIELD_W-1:0] ray_dir;
    logic [FIELD_W-1:0] vertex0;
    logic [FIELD_W-1:0] vertex1;
    logic [FIELD_W-1:0] vertex2;
  } rti_in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } rti_out_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic sat;
  } rti_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/rti_geom.sv]
// Edge, cross product and dot product stages of the intersection pipeline.
`default_nettype none
module rti_geom
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire                                  in_vld,
  input  rti_in_t                              in_data,
  output logic                                 out_vld,
  output logic signed [3*COORD_BITS+5:0]       a_o,
  output logic signed [3*COORD_BITS+5:0]       u_o,
  output logic signed [3*COORD_BITS+5:0]       v_o,
  output logic signed [3*COORD_BITS+5:0]       t_o
);

  localparam int C = COORD_BITS;
  localparam int E = C + 1;
  localparam int P = 2 * E;
  localparam int H = P + 1;
  localparam int D = E + H;
  localparam int W = D + 2;

  logic [63:0] w_org, w_dir, w_v0, w_v1, w_v2;
  logic [4:0]  vld_r;

  logic signed [E-1:0] s1_e1_r [3];
  logic signed [E-1:0] s1_e2_r [3];
  logic signed [E-1:0] s1_s_r  [3];
  logic signed [E-1:0] s1_d_r  [3];
  logic signed [E-1:0] s2_e1_r [3];
  logic signed [E-1:0] s2_e2_r [3];
  logic signed [E-1:0] s2_s_r  [3];
  logic signed [E-1:0] s2_d_r  [3];
  logic signed [E-1:0] s3_e1_r [3];
  logic signed [E-1:0] s3_e2_r [3];
  logic signed [E-1:0] s3_s_r  [3];
  logic signed [E-1:0] s3_d_r  [3];
  logic signed [P-1:0] hpa_r   [3];
  logic signed [P-1:0] hpb_r   [3];
  logic signed [P-1:0] qpa_r   [3];
  logic signed [P-1:0] qpb_r   [3];
  logic signed [H-1:0] h_r     [3];
  logic signed [H-1:0] q_r     [3];
  logic signed [D-1:0] ap_r    [3];
  logic signed [D-1:0] up_r    [3];
  logic signed [D-1:0] vp_r    [3];
  logic signed [D-1:0] tp_r    [3];

  assign w_org = {16'b0, in_data.ray_origin};
  assign w_dir = {16'b0, in_data.ray_dir};
  assign w_v0  = {16'b0, in_data.vertex0};
  assign w_v1  = {16'b0, in_data.vertex1};
  assign w_v2  = {16'b0, in_data.vertex2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    logic signed [C-1:0] oc, dc, v0c, v1c, v2c;

    assign oc  = w_org[k*C +: C];
    assign dc  = w_dir[k*C +: C];
    assign v0c = w_v0[k*C +: C];
    assign v1c = w_v1[k*C +: C];
    assign v2c = w_v2[k*C +: C];

    always_ff @(posedge clk) begin
      if (en) begin
        s1_e1_r[k] <= E'(v1c) - E'(v0c);
        s1_e2_r[k] <= E'(v2c) - E'(v0c);
        s1_s_r[k]  <= E'(oc) - E'(v0c);
        s1_d_r[k]  <= E'(dc);

        hpa_r[k] <= P'(s1_d_r[I1]) * P'(s1_e2_r[I2]);
        hpb_r[k] <= P'(s1_d_r[I2]) * P'(s1_e2_r[I1]);
        qpa_r[k] <= P'(s1_s_r[I1]) * P'(s1_e1_r[I2]);
        qpb_r[k] <= P'(s1_s_r[I2]) * P'(s1_e1_r[I1]);
        s2_e1_r[k] <= s1_e1_r[k];
        s2_e2_r[k] <= s1_e2_r[k];
        s2_s_r[k]  <= s1_s_r[k];
        s2_d_r[k]  <= s1_d_r[k];

        h_r[k] <= H'(hpa_r[k]) - H'(hpb_r[k]);
        q_r[k] <= H'(qpa_r[k]) - H'(qpb_r[k]);
        s3_e1_r[k] <= s2_e1_r[k];
        s3_e2_r[k] <= s2_e2_r[k];
        s3_s_r[k]  <= s2_s_r[k];
        s3_d_r[k]  <= s2_d_r[k];

        ap_r[k] <= D'(s3_e1_r[k]) * D'(h_r[k]);
        up_r[k] <= D'(s3_s_r[k]) * D'(h_r[k]);
        vp_r[k] <= D'(s3_d_r[k]) * D'(q_r[k]);
        tp_r[k] <= D'(s3_e2_r[k]) * D'(q_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_o <= W'(ap_r[0]) + W'(ap_r[1]) + W'(ap_r[2]);
      u_o <= W'(up_r[0]) + W'(up_r[1]) + W'(up_r[2]);
      v_o <= W'(vp_r[0]) + W'(vp_r[1]) + W'(vp_r[2]);
      t_o <= W'(tp_r[0]) + W'(tp_r[1]) + W'(tp_r[2]);
    end
  end

  assign out_vld = vld_r[4];

endmodule
`default_nettype wire

[hw/rtl/rti_test.sv]
// Sign normalization, rejection tests and divider setup stages.
`default_nettype none
module rti_test
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            en,
  input  wire                            in_vld,
  input  wire signed [3*COORD_BITS+5:0]  a_i,
  input  wire signed [3*COORD_BITS+5:0]  u_i,
  input  wire signed [3*COORD_BITS+5:0]  v_i,
  input  wire signed [3*COORD_BITS+5:0]  t_i,
  input  wire        [CFG_W-1:0]         thr,
  output rti_ctl_t                       ctl_o,
  output logic       [3*COORD_BITS+5:0]  rem_o,
  output logic       [DIST_W-1:0]        num_o,
  output logic       [3*COORD_BITS+5:0]  div_o
);

  localparam int W  = 3 * COORD_BITS + 6;
  localparam int WT = (W > CFG_W) ? W : CFG_W;
  localparam int WS = W + DIV_SHIFT;

  logic                vld6_r;
  logic signed [W-1:0] an_r, un_r, vn_r, tn_r;
  logic signed [W:0]   uv;
  logic                ok;
  logic                sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else if (en) begin
      vld6_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_i[W-1]) begin
        an_r <= -a_i;
        un_r <= -u_i;
        vn_r <= -v_i;
        tn_r <= -t_i;
      end else begin
        an_r <= a_i;
        un_r <= u_i;
        vn_r <= v_i;
        tn_r <= t_i;
      end
    end
  end

  always_comb begin
    uv  = (W+1)'(un_r) + (W+1)'(vn_r);
    ok  = (an_r != '0) && !an_r[W-1]
          && (WT'($unsigned(an_r)) >= WT'(thr))
          && !un_r[W-1] && (un_r <= an_r)
          && !vn_r[W-1] && (uv <= (W+1)'(an_r))
          && !tn_r[W-1] && (tn_r != '0);
    sat = WS'($unsigned(tn_r)) >= (WS'($unsigned(an_r)) << DIV_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= '{valid: vld6_r, ok: ok, sat: sat};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= $unsigned(tn_r) >> DIV_SHIFT;
      num_o <= {tn_r[DIV_SHIFT-1:0], (DIST_W-DIV_SHIFT)'(0)};
      div_o <= $unsigned(an_r);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rti_div.sv]
// Pipelined restoring divider producing one quotient bit per stage.
`default_nettype none
module rti_div
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  rti_ctl_t                      ctl_i,
  input  wire       [3*COORD_BITS+5:0]  rem_i,
  input  wire       [DIST_W-1:0]        num_i,
  input  wire       [3*COORD_BITS+5:0]  div_i,
  output rti_ctl_t                      ctl_o,
  output logic      [DIST_W-1:0]        dist_o
);

  localparam int W    = 3 * COORD_BITS + 6;
  localparam int LAST = DIST_W - 1;

  rti_ctl_t          ctl_r [DIST_W];
  logic [DIST_W-1:0] x_r   [DIST_W];
  logic [W-1:0]      rem_r [DIST_W-1];
  logic [W-1:0]      div_r [DIST_W-1];

  for (genvar j = 0; j < DIST_W; j++) begin : g_step
    rti_ctl_t          ctlp;
    logic [DIST_W-1:0] xp;
    logic [W-1:0]      remp, divp, rs;
    logic              ge;

    if (j == 0) begin : g_first
      assign ctlp = ctl_i;
      assign xp   = num_i;
      assign remp = rem_i;
      assign divp = div_i;
    end else begin : g_next
      assign ctlp = ctl_r[j-1];
      assign xp   = x_r[j-1];
      assign remp = rem_r[j-1];
      assign divp = div_r[j-1];
    end

    assign rs = {remp[W-2:0], xp[DIST_W-1]};
    assign ge = rs >= divp;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (en) begin
        ctl_r[j] <= ctlp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j] <= {xp[DIST_W-2:0], ge};
      end
    end

    if (j < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? rs - divp : rs;
          div_r[j] <= divp;
        end
      end
    end
  end

  assign ctl_o  = ctl_r[LAST];
  assign dist_o = ctl_r[LAST].sat ? '1 : x_r[LAST];

endmodule
`default_nettype wire

[hw/rtl/ray_triangle_intersect.sv]
// Top level of the pipelined ray/triangle intersection unit.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   rti_in_t  (ray and triangle)
//   out_     output     out_valid / out_stall rti_out_t (hit, Q16.16 distance)
//   cfg_     input      cfg_we                cfg_idx, cfg_wdata
//
// One transfer is accepted every cycle while in_stall is low.
// The pipeline is made of the 32 quotient stages of the divider plus eight
// stages of edges, products, sums, tests and the output register.
// The whole pipeline holds while the output register is full and stalled.
// Reset is synchronous, clears the valid bits and sets the two config registers to one.
`default_nettype none
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  rti_in_t              in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rti_out_t             out_data,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_W-1:0]      cfg_wdata
);

  localparam int W = 3 * COORD_BITS + 6;

  logic              en;
  logic [CFG_W-1:0]  det_thr_r, min_dist_r;
  logic              g_vld;
  logic signed [W-1:0] a_s, u_s, v_s, t_s;
  rti_ctl_t          t_ctl, d_ctl;
  logic [W-1:0]      t_rem, t_div;
  logic [DIST_W-1:0] t_num, d_dist;
  logic              out_valid_r;
  rti_out_t          out_data_r, out_data_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r  <= DET_THRESHOLD_RST;
      min_dist_r <= MIN_DISTANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DET_THRESHOLD: det_thr_r  <= cfg_wdata;
        CFG_MIN_DISTANCE:  min_dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rti_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .out_vld (g_vld),
    .a_o     (a_s),
    .u_o     (u_s),
    .v_o     (v_s),
    .t_o     (t_s)
  );

  rti_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (g_vld),
    .a_i    (a_s),
    .u_i    (u_s),
    .v_i    (v_s),
    .t_i    (t_s),
    .thr    (det_thr_r),
    .ctl_o  (t_ctl),
    .rem_o  (t_rem),
    .num_o  (t_num),
    .div_o  (t_div)
  );

  rti_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (t_ctl),
    .rem_i  (t_rem),
    .num_i  (t_num),
    .div_i  (t_div),
    .ctl_o  (d_ctl),
    .dist_o (d_dist)
  );

  always_comb begin
    out_data_nxt.hit      = d_ctl.ok && (d_dist > min_dist_r);
    out_data_nxt.distance = out_data_nxt.hit ? d_dist : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hw/rtl/rti_checker.sv]
// Port-level assertions for the intersection unit and their binding.
`default_nettype none
module rti_checker
  import rti_pkg::*;
(
  input wire      clk,
  input wire      rst_n,
  input wire      in_stall,
  input wire      out_valid,
  input wire      out_stall,
  input rti_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output side is free");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.distance == '0)
    else $error("miss carries a nonzero distance");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.distance != '0)
    else $error("hit carries a zero distance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
